FILE: sv/median_3x3_filter_assert.svh
// Assertion macros shared by the median filter RTL.
`ifndef MEDIAN_3X3_FILTER_ASSERT_SVH
`define MEDIAN_3X3_FILTER_ASSERT_SVH

// Property checked on every rising clock edge, silent while reset is held.
`define M3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Antecedent in one cycle implies the consequent in the next cycle.
`define M3_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/med3x3_pkg.sv
// Package with the constants and register codes of the 3x3 median filter.
`timescale 1ns / 1ps

package med3x3_pkg;

  // Default sizes of the line stores and of one pixel.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int PIXEL_BITS_DEF = 8;

  // Fixed field widths of the ports, size registers and row counter.
  localparam int PIX_PORT_W = 8;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int ROW_W      = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  // Frame limits and reset sizes.
  localparam int MIN_SIZE     = 3;
  localparam int MAX_HEIGHT   = 4096;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_e;

endpackage

FILE: sv/median_3x3_filter.sv
// 3x3 median filter over a raster-order pixel stream with two line stores.
//
//  Channel | Signals                                      | Direction
//  --------+----------------------------------------------+----------
//  cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i           | in
//  in      | in_valid_i/in_ready_o, pixel_in_i, flush_i   | in
//  out     | out_valid_o/out_ready_i, pixel_out_o,        | out
//          | frame_last_o                                 |
//
// One item is taken per clock unless a full pipeline, a configuration write or a
// width recompute holds input off; a result passes through the line-store read,
// window and three median stages to the output register. A write to image_width
// starts a serial division of the output count by the new width, one quotient bit
// per cycle, while input is held off. Reset needs no clearing pass: unwritten
// line-store entries only reach border outputs, which are forced to zero.
// A stalled output fills the pipeline stages before input ready drops.
`timescale 1ns / 1ps

`include "median_3x3_filter_assert.svh"

module median_3x3_filter #(
  parameter int MaxWidth  = med3x3_pkg::MAX_WIDTH_DEF,
  parameter int PixelBits = med3x3_pkg::PIXEL_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [med3x3_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [med3x3_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [med3x3_pkg::PIX_PORT_W-1:0]    pixel_in_i,
  input  logic                                 flush_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [med3x3_pkg::PIX_PORT_W-1:0]    pixel_out_o,
  output logic                                 frame_last_o
);

  localparam int AddrW   = (MaxWidth > 1) ? $clog2(MaxWidth) : 1;
  localparam int CntW    = $clog2(MaxWidth * med3x3_pkg::MAX_HEIGHT);
  localparam int DivCntW = $clog2(CntW + 1);
  localparam int WW      = med3x3_pkg::WIDTH_W;
  localparam int HW      = med3x3_pkg::HEIGHT_W;
  localparam int RW      = med3x3_pkg::ROW_W;
  localparam int PW      = med3x3_pkg::PIX_PORT_W;

  typedef logic [PixelBits-1:0] pix_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  // Configuration registers and their clamped values.
  logic [WW-1:0] width_q;
  logic [HW-1:0] height_q;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          width_wr;

  assign width_wr = cfg_we_i &&
                    (med3x3_pkg::cfg_reg_e'(cfg_index_i) == med3x3_pkg::REG_IMAGE_WIDTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(med3x3_pkg::WIDTH_RESET);
      height_q <= HW'(med3x3_pkg::HEIGHT_RESET);
    end else if (cfg_we_i) begin
      unique case (med3x3_pkg::cfg_reg_e'(cfg_index_i))
        med3x3_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[WW-1:0];
        med3x3_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[HW-1:0];
      endcase
    end
  end

  always_comb begin
    w_eff = width_q;
    if (32'(width_q) < med3x3_pkg::MIN_SIZE) begin
      w_eff = WW'(med3x3_pkg::MIN_SIZE);
    end else if (32'(width_q) > MaxWidth) begin
      w_eff = WW'(MaxWidth);
    end
    h_eff = height_q;
    if (32'(height_q) < med3x3_pkg::MIN_SIZE) begin
      h_eff = HW'(med3x3_pkg::MIN_SIZE);
    end else if (32'(height_q) > med3x3_pkg::MAX_HEIGHT) begin
      h_eff = HW'(med3x3_pkg::MAX_HEIGHT);
    end
  end

  // Position counters of the input and output streams.
  logic [AddrW-1:0] in_col_q, in_col_d;
  logic [RW-1:0]    in_row_q, in_row_d;
  logic             draining_q, draining_d;
  logic [CntW-1:0]  out_cnt_q, out_cnt_d;
  logic [CntW-1:0]  orow_q, orow_d;
  logic [AddrW-1:0] ocol_q, ocol_d;

  // Serial divider that rebuilds the output row and column after a width change.
  logic               div_busy_q;
  logic [DivCntW-1:0] div_cnt_q;
  logic [CntW-1:0]    div_dvd_q, div_dvd_next;
  logic [WW-1:0]      div_rem_q, div_rem_next;
  logic [WW:0]        div_trial;
  logic               div_ge;
  logic               div_done;

  always_comb begin
    div_trial    = {div_rem_q, div_dvd_q[CntW-1]};
    div_ge       = (div_trial >= {1'b0, w_eff});
    div_rem_next = div_ge ? WW'(div_trial - {1'b0, w_eff}) : div_trial[WW-1:0];
    div_dvd_next = {div_dvd_q[CntW-2:0], div_ge};
    div_done     = div_busy_q && (div_cnt_q == DivCntW'(CntW - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
    end else if (width_wr) begin
      div_busy_q <= 1'b1;
      div_cnt_q  <= '0;
    end else if (div_busy_q) begin
      div_busy_q <= !div_done;
      div_cnt_q  <= div_cnt_q + DivCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (width_wr) begin
      div_dvd_q <= out_cnt_q;
      div_rem_q <= '0;
    end else if (div_busy_q) begin
      div_dvd_q <= div_dvd_next;
      div_rem_q <= div_rem_next;
    end
  end

  // Pipeline handshake: each stage takes a new entry when it is empty or moving on.
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic s1_pix_q, s1_emit_q;
  logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, out_rdy, s1_go;
  logic accept, is_pix, enter_s1, produce, do_emit, emit_zero, emit_last;

  assign out_rdy    = !out_v_q || out_ready_i;
  assign s4_rdy     = !s4_v_q || out_rdy;
  assign s3_rdy     = !s3_v_q || s4_rdy;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || !s1_emit_q || s2_rdy;
  assign s1_go      = s1_v_q && s1_rdy;
  assign in_ready_o = s1_rdy && !div_busy_q && !cfg_we_i;
  assign accept     = in_valid_i && in_ready_o;

  // Item decode: a pixel shifts the window, a drain step only emits.
  always_comb begin
    is_pix    = !draining_q && !flush_i;
    enter_s1  = accept && (draining_q || !flush_i);
    produce   = (32'(in_row_q) >= 2) || ((32'(in_row_q) == 1) && (32'(in_col_q) >= 1));
    do_emit   = draining_q || (!flush_i && produce);
    emit_zero = !((32'(orow_q) >= 1) && (32'(orow_q) + 2 <= 32'(h_eff)) &&
                  (32'(ocol_q) >= 1) && (32'(ocol_q) + 2 <= 32'(w_eff)));
    emit_last = (32'(orow_q) > 32'(h_eff) - 1) ||
                ((32'(orow_q) == 32'(h_eff) - 1) && (32'(ocol_q) + 1 == 32'(w_eff)));
  end

  // Next values of the position counters.
  always_comb begin
    in_col_d   = in_col_q;
    in_row_d   = in_row_q;
    draining_d = draining_q;
    out_cnt_d  = out_cnt_q;
    orow_d     = orow_q;
    ocol_d     = ocol_q;
    if (accept && is_pix) begin
      if (32'(in_col_q) + 1 >= 32'(w_eff)) begin
        in_col_d = '0;
        if (32'(in_row_q) + 1 >= 32'(h_eff)) begin
          in_row_d   = '0;
          draining_d = 1'b1;
        end else begin
          in_row_d = in_row_q + RW'(1);
        end
      end else begin
        in_col_d = in_col_q + AddrW'(1);
      end
    end
    if (accept && do_emit) begin
      if (emit_last) begin
        in_col_d   = '0;
        in_row_d   = '0;
        draining_d = 1'b0;
        out_cnt_d  = '0;
        orow_d     = '0;
        ocol_d     = '0;
      end else begin
        out_cnt_d = out_cnt_q + CntW'(1);
        if (32'(ocol_q) + 1 >= 32'(w_eff)) begin
          ocol_d = '0;
          orow_d = orow_q + CntW'(1);
        end else begin
          ocol_d = ocol_q + AddrW'(1);
        end
      end
    end
    if (div_done) begin
      orow_d = div_dvd_next;
      ocol_d = AddrW'(div_rem_next);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      draining_q <= 1'b0;
      out_cnt_q  <= '0;
      orow_q     <= '0;
      ocol_q     <= '0;
    end else begin
      in_col_q   <= in_col_d;
      in_row_q   <= in_row_d;
      draining_q <= draining_d;
      out_cnt_q  <= out_cnt_d;
      orow_q     <= orow_d;
      ocol_q     <= ocol_d;
    end
  end

  // Line stores: read both rows at the input column, write the new pixel at once,
  // and move the old middle row up from its registered read data when stage 1 moves on.
  pix_t             row_above_mem [MaxWidth];
  pix_t             row_two_above_mem [MaxWidth];
  pix_t             top_q, mid_q;
  pix_t             px;
  logic             mem_en;
  pix_t             s1_px_q;
  logic [AddrW-1:0] s1_col_q;
  logic             s1_zero_q, s1_last_q;

  assign px     = PixelBits'({{PixelBits{1'b0}}, pixel_in_i});
  assign mem_en = accept && is_pix;

  always_ff @(posedge clk_i) begin
    if (mem_en) begin
      top_q                   <= row_two_above_mem[in_col_q];
      mid_q                   <= row_above_mem[in_col_q];
      row_above_mem[in_col_q] <= px;
    end
    if (s1_go && s1_pix_q) begin
      row_two_above_mem[s1_col_q] <= mid_q;
    end
  end

  // Stage 1 holds the item together with its registered line-store data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= enter_s1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && enter_s1) begin
      s1_pix_q  <= is_pix;
      s1_emit_q <= do_emit;
      s1_zero_q <= emit_zero;
      s1_last_q <= emit_last;
      s1_px_q   <= px;
      s1_col_q  <= in_col_q;
    end
  end

  // Window shifts in one column per pixel.
  pix_t window_q [9];
  pix_t win_next [9];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      win_next[k] = window_q[k];
    end
    if (s1_pix_q) begin
      for (int k = 0; k < 3; k++) begin
        win_next[k*3]   = window_q[k*3+1];
        win_next[k*3+1] = window_q[k*3+2];
      end
      win_next[2] = top_q;
      win_next[5] = mid_q;
      win_next[8] = s1_px_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        window_q[k] <= '0;
      end
    end else if (s1_go) begin
      for (int k = 0; k < 9; k++) begin
        window_q[k] <= win_next[k];
      end
    end
  end

  // Stage valids of the median network and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s2_rdy) begin
        s2_v_q <= s1_v_q && s1_emit_q;
      end
      if (s3_rdy) begin
        s3_v_q <= s2_v_q;
      end
      if (s4_rdy) begin
        s4_v_q <= s3_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s4_v_q;
      end
    end
  end

  // Median of nine: sort each row, combine row extremes, take the middle of three.
  pix_t          s2_win_q [9];
  logic          s2_zero_q, s2_last_q;
  pix_t          s3_lo_q [3];
  pix_t          s3_mid_q [3];
  pix_t          s3_hi_q [3];
  logic          s3_zero_q, s3_last_q;
  pix_t          s4_a_q, s4_b_q, s4_c_q;
  logic          s4_zero_q, s4_last_q;
  logic [PW-1:0] out_pix_q;
  logic          out_last_q;

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q && s1_emit_q) begin
      for (int k = 0; k < 9; k++) begin
        s2_win_q[k] <= win_next[k];
      end
      s2_zero_q <= s1_zero_q;
      s2_last_q <= s1_last_q;
    end
    if (s3_rdy && s2_v_q) begin
      for (int r = 0; r < 3; r++) begin
        s3_lo_q[r]  <= min2(min2(s2_win_q[r*3], s2_win_q[r*3+1]), s2_win_q[r*3+2]);
        s3_mid_q[r] <= med3(s2_win_q[r*3], s2_win_q[r*3+1], s2_win_q[r*3+2]);
        s3_hi_q[r]  <= max2(max2(s2_win_q[r*3], s2_win_q[r*3+1]), s2_win_q[r*3+2]);
      end
      s3_zero_q <= s2_zero_q;
      s3_last_q <= s2_last_q;
    end
    if (s4_rdy && s3_v_q) begin
      s4_a_q    <= max2(max2(s3_lo_q[0], s3_lo_q[1]), s3_lo_q[2]);
      s4_b_q    <= med3(s3_mid_q[0], s3_mid_q[1], s3_mid_q[2]);
      s4_c_q    <= min2(min2(s3_hi_q[0], s3_hi_q[1]), s3_hi_q[2]);
      s4_zero_q <= s3_zero_q;
      s4_last_q <= s3_last_q;
    end
    if (out_rdy && s4_v_q) begin
      if (s4_zero_q) begin
        out_pix_q <= '0;
      end else begin
        out_pix_q <= PW'({{PW{1'b0}}, med3(s4_a_q, s4_b_q, s4_c_q)});
      end
      out_last_q <= s4_last_q;
    end
  end

  assign out_valid_o  = out_v_q;
  assign pixel_out_o  = out_pix_q;
  assign frame_last_o = out_last_q;

  // The last pixel of a frame always lies on the bottom border.
  `M3_ASSERT(a_last_is_border, !(out_valid_o && frame_last_o) || (pixel_out_o == '0),
             "frame_last result carries a nonzero pixel")

  // Ending a frame returns every stream counter to its start.
  `M3_ASSERT_NEXT(a_frame_end_clears, accept && do_emit && emit_last,
                  (out_cnt_q == '0) && (in_col_q == '0) && (in_row_q == '0) && !draining_q,
                  "counters not cleared after the last output of a frame")

  // Outside a width recompute the output column stays inside the row.
  `M3_ASSERT(a_ocol_in_row, div_busy_q || (32'(ocol_q) < 32'(w_eff)),
             "output column beyond the image width")

endmodule

FILE: tb/sv/median_3x3_filter_test.sv
// Self-checking testbench for the 3x3 median filter, driven with directed and random frames.
`timescale 1ns / 1ps

module median_3x3_filter_test;
  import med3x3_pkg::*;

  localparam int QUIET_LIMIT   = 1000;
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES   = 20;
  localparam int MAX_SHOWN     = 10;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int UNBOUNDED     = 1 << 30;
  localparam int WIN_TAPS      = 9;
  localparam int MID_RANK      = 4;

  typedef enum int {
    PIX_UNIFORM,
    PIX_EXTREME,
    PIX_NARROW
  } pixel_mode_e;

  typedef struct packed {
    logic [PIX_PORT_W-1:0] pixel;
    logic                  last;
  } filter_out_t;

  // Block ports.
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = REG_IMAGE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [PIX_PORT_W-1:0] pixel_in_i  = '0;
  logic                  flush_i     = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [PIX_PORT_W-1:0] pixel_out_o;
  logic                  frame_last_o;

  // Predicted filter state.
  logic [PIX_PORT_W-1:0] line_above     [MAX_WIDTH_DEF];
  logic [PIX_PORT_W-1:0] line_two_above [MAX_WIDTH_DEF];
  logic [PIX_PORT_W-1:0] win            [WIN_TAPS];
  int unsigned           col_in;
  int unsigned           row_in;
  int unsigned           out_idx;
  bit                    draining;
  logic [WIDTH_W-1:0]    width_reg  = WIDTH_RESET;
  logic [HEIGHT_W-1:0]   height_reg = HEIGHT_RESET;

  filter_out_t           expected_out [$];
  int unsigned           mismatches;
  int unsigned           results_seen;
  int unsigned           used_items;
  int unsigned           quiet_cycles;
  int unsigned           ready_wait;
  bit                    steady;

  median_3x3_filter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_in_i  (pixel_in_i),
    .flush_i     (flush_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .pixel_out_o (pixel_out_o),
    .frame_last_o(frame_last_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Effective frame sizes after clamping the register values.
  function automatic int unsigned eff_width();
    int unsigned w;
    w = width_reg;
    if (w < MIN_SIZE) w = MIN_SIZE;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = height_reg;
    if (h < MIN_SIZE) h = MIN_SIZE;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;
    return h;
  endfunction

  // The median is the tap with at most four smaller values and at least five not larger.
  function automatic logic [PIX_PORT_W-1:0] window_median();
    int i;
    int j;
    int below;
    int not_above;
    for (i = 0; i < WIN_TAPS; i++) begin
      below = 0;
      not_above = 0;
      for (j = 0; j < WIN_TAPS; j++) begin
        if (win[j] < win[i]) below++;
        if (win[j] <= win[i]) not_above++;
      end
      if (below <= MID_RANK && not_above > MID_RANK) return win[i];
    end
    return '0;
  endfunction

  // Queue the output pixel at the current output position; border pixels are zero.
  function automatic void push_output(input int unsigned w, input int unsigned h);
    int unsigned orow;
    int unsigned ocol;
    filter_out_t res;
    orow = out_idx / w;
    ocol = out_idx % w;
    res.pixel = '0;
    if (orow >= 1 && orow + 2 <= h && ocol >= 1 && ocol + 2 <= w) begin
      res.pixel = window_median();
    end
    res.last = (out_idx + 1 >= w * h);
    if (res.last) begin
      col_in = 0;
      row_in = 0;
      out_idx = 0;
      draining = 1'b0;
    end else begin
      out_idx++;
    end
    expected_out.push_back(res);
  endfunction

  // Advance the prediction by one accepted item; returns 0 if the item is ignored.
  function automatic bit filter_step(input logic [PIX_PORT_W-1:0] pix, input logic fl);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int k;
    logic [PIX_PORT_W-1:0] top;
    logic [PIX_PORT_W-1:0] mid;
    bit produce;
    w = eff_width();
    h = eff_height();
    if (draining) begin
      push_output(w, h);
      return 1'b1;
    end
    if (fl) return 1'b0;

    c = (col_in >= MAX_WIDTH_DEF) ? MAX_WIDTH_DEF - 1 : col_in;
    top = line_two_above[c];
    mid = line_above[c];
    line_two_above[c] = mid;
    line_above[c] = pix;

    // Shift the window one column left and load the new column on the right.
    for (k = 0; k < 3; k++) begin
      win[3*k]   = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = pix;

    produce = (row_in >= 2) || (row_in == 1 && col_in >= 1);
    if (col_in + 1 >= w) begin
      col_in = 0;
      if (row_in + 1 >= h) begin
        row_in = 0;
        draining = 1'b1;
      end else begin
        row_in++;
      end
    end else begin
      col_in++;
    end
    if (produce) push_output(w, h);
    return 1'b1;
  endfunction

  function automatic logic [PIX_PORT_W-1:0] pick_pixel(input pixel_mode_e mode);
    logic [PIX_PORT_W-1:0] v;
    case (mode)
      PIX_EXTREME: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      PIX_NARROW:  v = 8'd126 + $urandom_range(0, 3);
      default:     v = $urandom_range(0, 255);
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_width();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 2);
    if (r < 3) return $urandom_range(13, 64);
    return $urandom_range(3, 12);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_height();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom_range(0, 2);
    if (r < 3) return $urandom_range(9, 20);
    return $urandom_range(3, 8);
  endfunction

  // Offer one item after a random gap, none while steady, and hold it until the transfer.
  task automatic send_item(input logic [PIX_PORT_W-1:0] pix, input logic fl);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_in_i <= pix;
    flush_i    <= fl;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (filter_step(pix, fl)) used_items++;
  endtask

  // Hold off input until every queued result has come out and the pipeline is empty.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Both size registers are written back to back while the block is idle.
  task automatic set_frame_size(input logic [CFG_DATA_W-1:0] wv,
                                input logic [CFG_DATA_W-1:0] hv);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_IMAGE_WIDTH;
    cfg_wdata_i <= wv;
    @(posedge clk_i);
    cfg_index_i <= REG_IMAGE_HEIGHT;
    cfg_wdata_i <= hv;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    width_reg  = wv[WIDTH_W-1:0];
    height_reg = hv;
  endtask

  // Send up to count pixels, with flush noise, stopping once the frame is fully taken.
  task automatic stream_pixels(input int count, input pixel_mode_e mode, input int flush_pct);
    int n;
    for (n = 0; n < count && !draining; n++) begin
      if ($urandom_range(0, 99) < flush_pct) send_item($urandom_range(0, 255), 1'b1);
      send_item(pick_pixel(mode), 1'b0);
    end
  endtask

  // Complete the frame in progress, or a whole new one, including the drain items.
  task automatic run_frame(input pixel_mode_e mode, input int flush_pct);
    stream_pixels(UNBOUNDED, mode, flush_pct);
    while (draining) send_item($urandom_range(0, 255), $urandom_range(0, 1));
  endtask

  // Smallest frame from clamped sizes: pixel extremes, an ignored flush, and drain
  // items that mix pixels with flushes.
  task automatic test_smallest_frame();
    set_frame_size(13'd0, 13'd1);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'h55, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hAA, 1'b0);
    send_item(8'h55, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    send_item(8'h7F, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  // All-ones width clamps to the widest line; this also fills every line-store entry.
  task automatic test_widest_frame();
    set_frame_size(13'h1FFF, 13'd3);
    run_frame(PIX_UNIFORM, 2);
  endtask

  // All-ones height clamps to the tallest frame; sent without idling to keep it short.
  task automatic test_tallest_frame();
    steady = 1'b1;
    set_frame_size(13'd3, 13'h1FFF);
    run_frame(PIX_NARROW, 0);
    steady = 1'b0;
  endtask

  // Sizes changed while a frame is open: counters wrap or the frame ends early.
  task automatic test_resize_mid_frame();
    set_frame_size(13'd8, 13'd6);
    stream_pixels(20, PIX_UNIFORM, 5);
    set_frame_size(13'd6, 13'd9);
    run_frame(PIX_UNIFORM, 5);

    set_frame_size(13'd10, 13'd5);
    stream_pixels(37, PIX_EXTREME, 0);
    set_frame_size(13'd14, 13'd4);
    run_frame(PIX_UNIFORM, 0);

    // Output count already past the new frame size: the next result closes the frame.
    set_frame_size(13'd12, 13'd8);
    stream_pixels(60, PIX_UNIFORM, 0);
    set_frame_size(13'd3, 13'd3);
    stream_pixels(1, PIX_UNIFORM, 0);
    run_frame(PIX_UNIFORM, 0);
  endtask

  // Random frames of mostly small sizes, with pauses and resizes inside some frames.
  task automatic test_random_frames();
    pixel_mode_e mode;
    used_items = 0;
    while (used_items < RANDOM_ITEMS) begin
      steady = ($urandom_range(0, 3) == 0);
      mode = pixel_mode_e'($urandom_range(0, 2));
      if ($urandom_range(0, 1)) set_frame_size(random_width(), random_height());
      if ($urandom_range(0, 5) == 0) begin
        stream_pixels($urandom_range(1, 40), mode, 5);
        if ($urandom_range(0, 1)) set_frame_size(random_width(), random_height());
        else settle();
      end
      run_frame(mode, $urandom_range(0, 10));
    end
    steady = 1'b0;
  endtask

  initial begin
    foreach (line_above[i]) begin
      line_above[i] = '0;
      line_two_above[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    col_in = 0;
    row_in = 0;
    out_idx = 0;
    draining = 1'b0;
    steady = 1'b0;
    mismatches = 0;
    results_seen = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_smallest_frame();
    test_widest_frame();
    test_tallest_frame();
    test_resize_mid_frame();
    test_random_frames();

    in_valid_i <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_out.size() == 0) begin
      $display("median_3x3_filter_test: done, clean");
    end else begin
      $display("median_3x3_filter_test: done, errors");
    end
    $finish;
  end

  // Output ready: after a transfer it drops at random, but never while steady.
  always @(posedge clk_i) begin : drive_ready
    int unsigned hold;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      ready_wait  <= 0;
    end else if (out_ready_i && out_valid_o) begin
      hold = steady ? 0 : $urandom_range(0, 4);
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        ready_wait  <= hold - 1;
      end
    end else if (!out_ready_i) begin
      if (ready_wait == 0) out_ready_i <= 1'b1;
      else ready_wait <= ready_wait - 1;
    end
  end

  // Compare every output transfer with the oldest predicted result.
  always @(posedge clk_i) begin : check_results
    filter_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_out.size() == 0) begin
        if (mismatches < MAX_SHOWN) begin
          $display("result %0d not expected: pixel %0d last %0b",
                   results_seen, pixel_out_o, frame_last_o);
        end
        mismatches++;
      end else begin
        want = expected_out.pop_front();
        if (pixel_out_o !== want.pixel || frame_last_o !== want.last) begin
          if (mismatches < MAX_SHOWN) begin
            $display("result %0d wrong: expected pixel %0d last %0b, got pixel %0d last %0b",
                     results_seen, want.pixel, want.last, pixel_out_o, frame_last_o);
          end
          mismatches++;
        end
      end
      results_seen++;
    end
  end

  // Stop the run if neither channel completes a transfer for too long.
  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("median_3x3_filter_test: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
